// File: rtl/cpa_pkg.sv
// Shared types and codes for the contiguous page allocator.
package cpa_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO       = 3'd1,
    ST_NOSPACE    = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_NOTSTART   = 3'd4
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    scan;
    logic    mark;
    logic    free_rd;
    logic    walk;
    logic    clear;
    logic    res_set;
    logic    res_ok_addr;
    status_e res_status;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_free;
    logic need_zero;
    logic need_big;
    logic misaligned;
    logic out_of_range;
    logic found;
    logic exhausted;
    logic mark_last;
    logic start_hit;
    logic page_cont;
    logic cur_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/cpa_ctrl.sv
// Controller state machine for the contiguous page allocator.
module cpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cpa_pkg::sts_t sts_i,
  output cpa_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_CLEAR      = 7'b0000001,
    S_IDLE       = 7'b0000010,
    S_ALLOC_SCAN = 7'b0000100,
    S_ALLOC_MARK = 7'b0001000,
    S_FREE_RD    = 7'b0010000,
    S_FREE_CHECK = 7'b0100000,
    S_FREE_WALK  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   resp_q, resp_d;

  always_comb begin
    cmd_o = '0;
    cmd_o.res_status = cpa_pkg::ST_OK;
    state_d = state_q;
    resp_d = resp_q;
    in_stall_o = (state_q != S_IDLE) || resp_q;

    // a pending response blocks everything until the output register frees up
    if (resp_q) begin
      if (sts_i.out_free) begin
        cmd_o.out_load = 1'b1;
        resp_d = 1'b0;
      end
    end else begin
      case (state_q)
        S_CLEAR: begin
          cmd_o.clear = 1'b1;
          if (sts_i.cur_last) state_d = S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_o.accept = 1'b1;
            if (!sts_i.op_free) begin
              if (sts_i.need_zero) begin
                cmd_o.res_set = 1'b1;
                cmd_o.res_status = cpa_pkg::ST_ZERO;
                resp_d = 1'b1;
              end else if (sts_i.need_big) begin
                cmd_o.res_set = 1'b1;
                cmd_o.res_status = cpa_pkg::ST_NOSPACE;
                resp_d = 1'b1;
              end else begin
                state_d = S_ALLOC_SCAN;
              end
            end else begin
              if (sts_i.misaligned) begin
                cmd_o.res_set = 1'b1;
                cmd_o.res_status = cpa_pkg::ST_MISALIGNED;
                resp_d = 1'b1;
              end else if (sts_i.out_of_range) begin
                cmd_o.res_set = 1'b1;
                cmd_o.res_status = cpa_pkg::ST_NOTSTART;
                resp_d = 1'b1;
              end else begin
                state_d = S_FREE_RD;
              end
            end
          end
        end
        S_ALLOC_SCAN: begin
          cmd_o.scan = 1'b1;
          if (sts_i.found) begin
            state_d = S_ALLOC_MARK;
          end else if (sts_i.exhausted) begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_status = cpa_pkg::ST_NOSPACE;
            resp_d = 1'b1;
            state_d = S_IDLE;
          end
        end
        S_ALLOC_MARK: begin
          cmd_o.mark = 1'b1;
          if (sts_i.mark_last) begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_ok_addr = 1'b1;
            cmd_o.res_status = cpa_pkg::ST_OK;
            resp_d = 1'b1;
            state_d = S_IDLE;
          end
        end
        S_FREE_RD: begin
          cmd_o.free_rd = 1'b1;
          state_d = S_FREE_CHECK;
        end
        S_FREE_CHECK: begin
          if (!sts_i.start_hit) begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_status = cpa_pkg::ST_NOTSTART;
            resp_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.walk = 1'b1;
            if (sts_i.cur_last) begin
              cmd_o.res_set = 1'b1;
              cmd_o.res_status = cpa_pkg::ST_OK;
              resp_d = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_FREE_WALK;
            end
          end
        end
        S_FREE_WALK: begin
          // clear pages until a block start, a free page or the last page
          if (sts_i.page_cont) cmd_o.walk = 1'b1;
          if (!sts_i.page_cont || sts_i.cur_last) begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_status = cpa_pkg::ST_OK;
            resp_d = 1'b1;
            state_d = S_IDLE;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      resp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output register overwritten while a result waits");

  a_no_accept_with_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_q |-> !cmd_o.accept)
    else $error("request accepted while a response is pending");

  a_state_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

endmodule

// File: rtl/cpa_dp.sv
// Datapath of the contiguous page allocator: page flag memory, scan and walk counters, result.
module cpa_dp #(
  parameter int NUM_PAGES = 1024,
  parameter int PAGE_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          operation_i,
  input  logic [31:0]   size_bytes_i,
  input  logic [31:0]   address_i,
  input  cpa_pkg::cmd_t cmd_i,
  output cpa_pkg::sts_t sts_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output logic [31:0]   block_address_o,
  output logic [2:0]    status_o
);

  localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam logic [31:0] PageMask = 32'((64'd1 << PAGE_BITS) - 64'd1);
  localparam logic [AW:0] ScanEnd = (AW+1)'(NUM_PAGES);
  localparam logic [AW-1:0] LastPage = AW'(NUM_PAGES - 1);

  // flag bit 1: block start, bit 0: allocated
  logic [1:0] mem_q [NUM_PAGES];
  logic [1:0] rd_data_q;

  logic [AW:0]     scan_q;
  logic            pend_q;
  logic [AW:0]     run_q;
  logic [AW-1:0]   cur_q;
  logic [AW:0]     need_q;
  logic [AW-1:0]   rd_idx_q;
  logic [AW-1:0]   start_q;
  logic [AW-1:0]   end_q;
  logic [31:0]     res_addr_q;
  cpa_pkg::status_e res_status_q;
  logic            out_valid_q;
  logic [31:0]     out_addr_q;
  cpa_pkg::status_e out_status_q;

  logic [32:0]   need_full;
  logic [31:0]   pfn;
  logic [AW:0]   run_inc;
  logic          page_free;
  logic [AW-1:0] start_sel;
  logic          found;
  logic          cur_last;
  logic          scan_more;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [1:0]    wr_data;

  always_comb begin
    need_full = {1'b0, size_bytes_i >> PAGE_BITS} + {32'd0, |(size_bytes_i & PageMask)};
    pfn       = address_i >> PAGE_BITS;
    run_inc   = run_q + (AW+1)'(1);
    page_free = !rd_data_q[0];
    start_sel = (run_q == '0) ? rd_idx_q : start_q;
    found     = pend_q && page_free && (run_inc == need_q);
    cur_last  = (cur_q == LastPage);
    scan_more = (scan_q != ScanEnd);
  end

  always_comb begin
    sts_o.op_free      = (cpa_pkg::op_e'(operation_i) == cpa_pkg::OP_FREE);
    sts_o.need_zero    = (need_full == 33'd0);
    sts_o.need_big     = (need_full > 33'(NUM_PAGES));
    sts_o.misaligned   = |(address_i & PageMask);
    sts_o.out_of_range = (pfn >= 32'(NUM_PAGES));
    sts_o.found        = found;
    sts_o.exhausted    = !scan_more && !pend_q;
    sts_o.mark_last    = (cur_q == end_q);
    sts_o.start_hit    = rd_data_q[1];
    sts_o.page_cont    = !rd_data_q[1] && rd_data_q[0];
    sts_o.cur_last     = cur_last;
    sts_o.out_free     = !out_valid_q || !out_stall_i;
  end

  // one read and one write port on the flag memory
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_q;
    if (cmd_i.scan && scan_more) begin
      rd_en   = 1'b1;
      rd_addr = scan_q[AW-1:0];
    end else if (cmd_i.free_rd) begin
      rd_en = 1'b1;
    end else if (cmd_i.walk && !cur_last) begin
      rd_en   = 1'b1;
      rd_addr = cur_q + AW'(1);
    end
    wr_en   = cmd_i.mark || cmd_i.walk || cmd_i.clear;
    wr_data = cmd_i.mark ? {(cur_q == start_q), 1'b1} : 2'b00;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[cur_q] <= wr_data;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      pend_q      <= 1'b0;
      run_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        scan_q <= '0;
        pend_q <= 1'b0;
        run_q  <= '0;
        cur_q  <= pfn[AW-1:0];
      end else if (cmd_i.scan) begin
        if (scan_more) begin
          scan_q <= scan_q + (AW+1)'(1);
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
        if (pend_q) begin
          if (page_free) begin
            run_q <= run_inc;
            if (found) cur_q <= start_sel;
          end else begin
            run_q <= '0;
          end
        end
      end else if (cmd_i.mark || cmd_i.walk || cmd_i.clear) begin
        cur_q <= cur_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) need_q <= need_full[AW:0];
    if (cmd_i.scan && scan_more) rd_idx_q <= scan_q[AW-1:0];
    if (cmd_i.scan && pend_q && page_free) begin
      start_q <= start_sel;
      if (found) end_q <= rd_idx_q;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_addr_q   <= cmd_i.res_ok_addr ? 32'(64'(start_q) << PAGE_BITS) : '1;
    end
    if (cmd_i.out_load) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign block_address_o = out_addr_q;
  assign status_o        = out_status_q;

  a_run_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (run_q < need_q))
    else $error("free run reached the page count without a hit");

  a_mark_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark |-> (cur_q >= start_q) && (cur_q <= end_q))
    else $error("marking outside the found run");

  a_fail_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != cpa_pkg::ST_OK)) |-> (out_addr_q == '1))
    else $error("failed request returned an address");

  a_addr_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == cpa_pkg::ST_OK)) |-> ((out_addr_q & PageMask) == '0)
      || (out_addr_q == '1))
    else $error("allocated address not page aligned");

endmodule

// File: rtl/contiguous_page_allocator_unit.sv
// Contiguous page allocator top level: first-fit allocate and free over a page flag memory.
// Keeps an allocated and a block-start flag for each of NUM_PAGES pages of 2^PAGE_BITS bytes in
// a flag memory with one read and one write port, visited one page per cycle. After reset a
// clearing pass zeroes the flags of every page; requests are stalled during it. An allocate
// scans pages up to the end of the first fitting run, then marks the pages of that run; a zero
// size or a size beyond memory answers without a scan. A free reads the flags of the given
// page, checks it for a block start and releases the pages of the block; a misaligned or out of
// range address answers without a read. One request is in flight at a time; its response sits
// in an output register, and the next request is taken as soon as that response is registered.
module contiguous_page_allocator_unit #(
  parameter int NUM_PAGES = 1024,
  parameter int PAGE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] size_bytes_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] block_address_o,
  output logic [2:0]  status_o
);

  cpa_pkg::cmd_t cmd;
  cpa_pkg::sts_t sts;

  cpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cpa_dp #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .operation_i     (operation_i),
    .size_bytes_i    (size_bytes_i),
    .address_i       (address_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .block_address_o (block_address_o),
    .status_o        (status_o)
  );

endmodule
